// File: src/bct_pkg.sv
// ----------------------------------------------------------------------------
// bct_pkg
// Shared types, constants and control structs of the Bezier curve tessellator.
// ----------------------------------------------------------------------------
package bct_pkg;

	// coordinate and parameter widths
	localparam int COORD_W   = 32;
	localparam int STEP_W    = 17;
	localparam int T_W       = 18;
	localparam int HELD_W    = 3;
	localparam int LVL_W     = 2;
	localparam int RES_CNT_W = 6;
	localparam int LANES     = 3;

	// defaults and limits
	localparam int MAX_CONTROL_POINTS_DEF = 4;
	localparam int RESULT_LIMIT           = 64;

	localparam logic [T_W-1:0]    ONE_Q16      = T_W'(65536);
	localparam logic [STEP_W-1:0] STEP_RESET   = STEP_W'(4096);
	localparam logic [HELD_W-1:0] HELD_SAT     = HELD_W'(7);
	localparam logic [HELD_W-1:0] CUBIC_POINTS = HELD_W'(4);
	localparam logic [HELD_W-1:0] MIN_POINTS   = HELD_W'(2);

	typedef logic signed [COORD_W-1:0] coord_t;

	// controller to datapath commands
	typedef struct packed {
		logic cfg_wr;
		logic store_pt;
		logic load_w;
		logic lerp_cap;
		logic lerp_mul;
		logic lerp_wb;
		logic drop;
		logic t_clear;
		logic t_step;
		logic out_load;
		logic out_last;
		logic out_bad;
	} bct_cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic t_next_le_one;
		logic t_next_lt_one;
	} bct_status_t;

endpackage

// File: src/bct_dpath.sv
// ----------------------------------------------------------------------------
// bct_dpath
// Point store, three-lane de Casteljau work queues, shared interpolation
// pipeline per lane, parameter accumulator and output payload register.
// ----------------------------------------------------------------------------
module bct_dpath #(
	parameter int MAX_CONTROL_POINTS = bct_pkg::MAX_CONTROL_POINTS_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  bct_pkg::bct_cmd_t                      cmd,
	input  logic [$clog2(MAX_CONTROL_POINTS)-1:0]  wr_idx,
	input  logic [bct_pkg::STEP_W-1:0]             step_q16,
	input  bct_pkg::coord_t                        point_x,
	input  bct_pkg::coord_t                        point_y,
	input  bct_pkg::coord_t                        point_z,
	output bct_pkg::bct_status_t                   status,
	output bct_pkg::coord_t                        curve_x,
	output bct_pkg::coord_t                        curve_y,
	output bct_pkg::coord_t                        curve_z,
	output logic                                   last_point,
	output logic                                   bad_count
);
	import bct_pkg::*;

	localparam int QL = MAX_CONTROL_POINTS;

	coord_t                 pt_in [LANES];
	coord_t                 store_q [LANES][QL];
	coord_t                 w_q [LANES][QL];
	coord_t                 a_s1 [LANES];
	logic signed [COORD_W:0] d_s1 [LANES];
	coord_t                 a_s2 [LANES];
	logic signed [50:0]     p_s2 [LANES];
	coord_t                 res [LANES];
	coord_t                 out_q [LANES];
	logic                   last_q;
	logic                   bad_q;
	logic [STEP_W-1:0]      step_q;
	logic [T_W-1:0]         t_q;
	logic [T_W-1:0]         t_nxt;

	assign pt_in[0] = point_x;
	assign pt_in[1] = point_y;
	assign pt_in[2] = point_z;

	// step register, reset to its default
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= STEP_RESET;
		end else if (cmd.cfg_wr) begin
			step_q <= step_q16;
		end
	end

	// parameter accumulator and bound checks on the next value
	assign t_nxt = t_q + T_W'(step_q);
	assign status.t_next_le_one = (t_nxt <= ONE_Q16);
	assign status.t_next_lt_one = (t_nxt < ONE_Q16);

	always_ff @(posedge clk) begin
		if (cmd.t_clear) begin
			t_q <= '0;
		end else if (cmd.t_step) begin
			t_q <= t_nxt;
		end
	end

	// interpolation result: a + floor(t * (b - a) / 65536)
	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			res[l] = a_s2[l] + coord_t'(p_s2[l][47:16]);
		end
	end

	// control point store, work queues and interpolation pipeline
	always_ff @(posedge clk) begin
		for (int l = 0; l < LANES; l++) begin
			if (cmd.store_pt) begin
				store_q[l][wr_idx] <= pt_in[l];
			end
			if (cmd.lerp_cap) begin
				a_s1[l] <= w_q[l][0];
				d_s1[l] <= {w_q[l][1][COORD_W-1], w_q[l][1]}
					- {w_q[l][0][COORD_W-1], w_q[l][0]};
			end
			if (cmd.lerp_mul) begin
				a_s2[l] <= a_s1[l];
				p_s2[l] <= 51'($signed({1'b0, t_q[16:0]})) * 51'(d_s1[l]);
			end
			if (cmd.load_w) begin
				for (int k = 0; k < QL; k++) begin
					w_q[l][k] <= store_q[l][k];
				end
			end else if (cmd.lerp_wb || cmd.drop) begin
				for (int k = 0; k < QL - 1; k++) begin
					w_q[l][k] <= w_q[l][k+1];
				end
				w_q[l][QL-1] <= cmd.lerp_wb ? res[l] : w_q[l][0];
			end
			if (cmd.out_load) begin
				out_q[l] <= cmd.out_bad ? '0 : w_q[l][QL-1];
			end
		end
		if (cmd.out_load) begin
			last_q <= cmd.out_last;
			bad_q  <= cmd.out_bad;
		end
	end

	assign curve_x    = out_q[0];
	assign curve_y    = out_q[1];
	assign curve_z    = out_q[2];
	assign last_point = last_q;
	assign bad_count  = bad_q;

endmodule

// File: src/bct_ctrl.sv
// ----------------------------------------------------------------------------
// bct_ctrl
// Controller: collects the point count, sequences the interpolation levels
// for each parameter value and drives the output handshake.
// ----------------------------------------------------------------------------
module bct_ctrl #(
	parameter int MAX_CONTROL_POINTS = bct_pkg::MAX_CONTROL_POINTS_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	output logic                                   in_ready,
	input  logic                                   last_of_set,
	output logic                                   out_valid,
	input  logic                                   out_ready,
	input  logic                                   cfg_valid,
	output logic                                   cfg_ready,
	input  bct_pkg::bct_status_t                   status,
	output bct_pkg::bct_cmd_t                      cmd,
	output logic [$clog2(MAX_CONTROL_POINTS)-1:0]  wr_idx
);
	import bct_pkg::*;

	localparam int IDX_W = $clog2(MAX_CONTROL_POINTS);
	localparam logic [HELD_W-1:0] MAX_HELD = HELD_W'(MAX_CONTROL_POINTS);

	typedef enum logic [2:0] {
		S_IDLE,
		S_BAD,
		S_LOAD,
		S_CAP,
		S_MUL,
		S_WB,
		S_DROP,
		S_EMIT
	} state_t;

	state_t                 state_q;
	logic [HELD_W-1:0]      held_q;
	logic [HELD_W-1:0]      held_nxt;
	logic [HELD_W-1:0]      n_q;
	logic [HELD_W-1:0]      drop_q;
	logic [LVL_W-1:0]       lvl_q;
	logic [LVL_W-1:0]       i_q;
	logic [RES_CNT_W-1:0]   cnt_q;
	logic                   cubic_q;
	logic                   out_valid_q;
	logic                   in_acc;
	logic                   out_free;
	logic                   emit_last;
	logic                   set_bad;

	assign in_ready  = (state_q == S_IDLE);
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign in_acc    = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;
	assign wr_idx    = held_q[IDX_W-1:0];

	// saturating count of points in the current set
	assign held_nxt = (held_q < HELD_SAT) ? held_q + HELD_W'(1) : held_q;
	assign set_bad  = (held_nxt < MIN_POINTS) || (held_nxt > MAX_HELD);

	// final result of a run: limit reached or next parameter out of range
	assign emit_last = (cnt_q == RES_CNT_W'(RESULT_LIMIT - 1))
		|| !(cubic_q ? status.t_next_lt_one : status.t_next_le_one);

	// command decode
	always_comb begin
		cmd        = '0;
		cmd.cfg_wr = cfg_valid && cfg_ready;
		case (state_q)
			S_IDLE: begin
				cmd.store_pt = in_acc && (held_q < MAX_HELD);
				cmd.t_clear  = in_acc;
			end
			S_BAD: begin
				cmd.out_load = out_free;
				cmd.out_last = 1'b1;
				cmd.out_bad  = 1'b1;
			end
			S_LOAD: cmd.load_w   = 1'b1;
			S_CAP:  cmd.lerp_cap = 1'b1;
			S_MUL:  cmd.lerp_mul = 1'b1;
			S_WB:   cmd.lerp_wb  = 1'b1;
			S_DROP: cmd.drop     = 1'b1;
			S_EMIT: begin
				cmd.out_load = out_free;
				cmd.out_last = emit_last;
				cmd.t_step   = out_free && !emit_last;
			end
			default: cmd = '0;
		endcase
	end

	// state, counters and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			held_q      <= '0;
			n_q         <= '0;
			drop_q      <= '0;
			lvl_q       <= '0;
			i_q         <= '0;
			cnt_q       <= '0;
			cubic_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= (out_valid_q && !out_ready) || cmd.out_load;
			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						if (last_of_set) begin
							held_q  <= '0;
							n_q     <= held_nxt;
							cubic_q <= (held_nxt == CUBIC_POINTS);
							cnt_q   <= '0;
							state_q <= set_bad ? S_BAD : S_LOAD;
						end else begin
							held_q <= held_nxt;
						end
					end
				end
				S_BAD: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				S_LOAD: begin
					lvl_q   <= LVL_W'(n_q - HELD_W'(1));
					i_q     <= '0;
					state_q <= S_CAP;
				end
				S_CAP: state_q <= S_MUL;
				S_MUL: state_q <= S_WB;
				S_WB: begin
					if (i_q == lvl_q - LVL_W'(1)) begin
						if (lvl_q == LVL_W'(1)) begin
							state_q <= S_EMIT;
						end else begin
							// realign the new level at the queue head
							drop_q  <= MAX_HELD - HELD_W'(lvl_q);
							lvl_q   <= lvl_q - LVL_W'(1);
							i_q     <= '0;
							state_q <= S_DROP;
						end
					end else begin
						i_q     <= i_q + LVL_W'(1);
						state_q <= S_CAP;
					end
				end
				S_DROP: begin
					drop_q <= drop_q - HELD_W'(1);
					if (drop_q == HELD_W'(1)) begin
						state_q <= S_CAP;
					end
				end
				S_EMIT: begin
					if (out_free) begin
						if (emit_last) begin
							state_q <= S_IDLE;
						end else begin
							cnt_q   <= cnt_q + RES_CNT_W'(1);
							state_q <= S_LOAD;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// File: src/bezier_curve_tessellator.sv
// ----------------------------------------------------------------------------
// bezier_curve_tessellator
// Collects up to four 3-D control points and emits the Bezier curve points
// by de Casteljau interpolation, t stepping by the configured increment.
// ----------------------------------------------------------------------------
// Control points: one per cycle while idle; a non-final point gives no result.
// Per curve point the controller steps through the interpolation (subtract,
// multiply, write back) that each lane reuses for every level, plus queue
// realign steps between levels.
// A bad point count gives a single flagged result, loaded from the bad state.
// Reset empties the point set, idles the controller and sets the step to 4096.
module bezier_curve_tessellator #(
	parameter int MAX_CONTROL_POINTS = bct_pkg::MAX_CONTROL_POINTS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [bct_pkg::STEP_W-1:0]  step_q16,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  bct_pkg::coord_t             point_x,
	input  bct_pkg::coord_t             point_y,
	input  bct_pkg::coord_t             point_z,
	input  logic                        last_of_set,
	output logic                        out_valid,
	input  logic                        out_ready,
	output bct_pkg::coord_t             curve_x,
	output bct_pkg::coord_t             curve_y,
	output bct_pkg::coord_t             curve_z,
	output logic                        last_point,
	output logic                        bad_count
);
	import bct_pkg::*;

	localparam int IDX_W = $clog2(MAX_CONTROL_POINTS);

	bct_cmd_t          cmd;
	bct_status_t       status;
	logic [IDX_W-1:0]  wr_idx;

	// controller
	bct_ctrl #(
		.MAX_CONTROL_POINTS(MAX_CONTROL_POINTS)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.last_of_set(last_of_set),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.status     (status),
		.cmd        (cmd),
		.wr_idx     (wr_idx)
	);

	// datapath
	bct_dpath #(
		.MAX_CONTROL_POINTS(MAX_CONTROL_POINTS)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.wr_idx    (wr_idx),
		.step_q16  (step_q16),
		.point_x   (point_x),
		.point_y   (point_y),
		.point_z   (point_z),
		.status    (status),
		.curve_x   (curve_x),
		.curve_y   (curve_y),
		.curve_z   (curve_z),
		.last_point(last_point),
		.bad_count (bad_count)
	);

endmodule

// File: src/bct_checker.sv
// ----------------------------------------------------------------------------
// bct_checker
// Port-level checks of the tessellator, bound to the top level.
// ----------------------------------------------------------------------------
module bct_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        last_of_set,
	input logic        out_valid,
	input logic        out_ready,
	input logic [31:0] curve_x,
	input logic [31:0] curve_y,
	input logic [31:0] curve_z,
	input logic        last_point,
	input logic        bad_count
);

	// a stalled result holds its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(curve_x)
			&& $stable(curve_y) && $stable(curve_z)
			&& $stable(last_point) && $stable(bad_count))
		else $error("result changed while stalled");

	// the final point of a set stops input until the run is done
	a_last_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && last_of_set |=> !in_ready)
		else $error("input taken right after final point");

	// a non-final point never starts a result
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && !last_of_set && !out_valid |=> !out_valid)
		else $error("result after non-final point");

	// a bad-count result is final and has zero coordinates
	a_bad_form: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && bad_count |-> last_point && curve_x == 32'd0
			&& curve_y == 32'd0 && curve_z == 32'd0)
		else $error("malformed bad count result");

endmodule

bind bezier_curve_tessellator bct_checker u_bct_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_ready   (in_ready),
	.last_of_set(last_of_set),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.curve_x    (curve_x),
	.curve_y    (curve_y),
	.curve_z    (curve_z),
	.last_point (last_point),
	.bad_count  (bad_count)
);
